// ===== design/cross_kernel_sharpen_filter_defines.svh =====
// Assertion macros used by the checker in cksf_checker.sv.
`ifndef CROSS_KERNEL_SHARPEN_FILTER_DEFINES_SVH
`define CROSS_KERNEL_SHARPEN_FILTER_DEFINES_SVH

// Same-cycle implication.
`define CKSF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CKSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cksf_pkg.sv =====
`timescale 1ns / 1ps

package cksf_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned NUM_CH_MAX  = 4;
  localparam int unsigned PIX_W       = NUM_CH_MAX * CHAN_W;
  localparam int unsigned COL_W       = 11;
  localparam int unsigned ROW_W       = 16;
  localparam int unsigned WIDTH_W     = 12;
  localparam int unsigned HEIGHT_W    = 16;
  localparam int unsigned GAIN_W      = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_CENTER_GAIN  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CHAN_W-1:0] chan0_in;
    logic [CHAN_W-1:0] chan1_in;
    logic [CHAN_W-1:0] chan2_in;
    logic [CHAN_W-1:0] chan3_in;
  } pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan0_out;
    logic [CHAN_W-1:0] chan1_out;
    logic [CHAN_W-1:0] chan2_out;
    logic [CHAN_W-1:0] chan3_out;
    logic [COL_W-1:0]  out_col;
    logic [ROW_W-1:0]  out_row;
    logic              last_of_item;
    logic              frame_done;
  } res_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             has_above;
    logic             border;
    logic             last_row;
    logic             last_col;
  } item_t;

endpackage

// ===== design/cksf_stream_if.sv =====
`timescale 1ns / 1ps

interface cksf_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/cross_kernel_sharpen_filter.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake       Item
// pix_i    in   valid/ready     one 4-channel pixel, raster order
// res_o    out  valid/ready     one sharpened pixel with coordinates
// cfg      in   cfg_we_i only   register write, index cfg_idx_i
//
// One pixel per cycle when res_o does not stall, set by the line store's single write port
// (one row word per item); a result leaves after the queue, line read and sum registers.
// Last-row pixels give two results; the back end takes no item while the second is out.
// Reset clears counters and the left hold; line stores are not cleared.
// A stall on res_o holds the back end; the 4-item queue keeps pix_i open for 4 more items.

module cross_kernel_sharpen_filter #(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned CHANNELS  = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cksf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cksf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  cksf_stream_if.sink                      pix_i,
  cksf_stream_if.source                    res_o
);

  logic [cksf_pkg::WIDTH_W-1:0]  image_width_q;
  logic [cksf_pkg::HEIGHT_W-1:0] image_height_q;
  logic [cksf_pkg::GAIN_W-1:0]   center_gain_q;

  logic            push, full, pop, q_valid;
  cksf_pkg::item_t push_item, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= cksf_pkg::WIDTH_RST;
      image_height_q <= cksf_pkg::HEIGHT_RST;
      center_gain_q  <= cksf_pkg::GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cksf_pkg::CFG_IMAGE_WIDTH: begin
          image_width_q <= cfg_data_i[cksf_pkg::WIDTH_W-1:0];
        end
        cksf_pkg::CFG_IMAGE_HEIGHT: begin
          image_height_q <= cfg_data_i[cksf_pkg::HEIGHT_W-1:0];
        end
        cksf_pkg::CFG_CENTER_GAIN: begin
          center_gain_q <= cfg_data_i[cksf_pkg::GAIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  cksf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .CHANNELS  (CHANNELS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .pix_i          (pix_i),
    .full_i         (full),
    .push_o         (push),
    .item_o         (push_item)
  );

  cksf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  cksf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .CHANNELS  (CHANNELS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .gain_i    (center_gain_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (pop),
    .res_o     (res_o)
  );

endmodule

// ===== design/cksf_front.sv =====
`timescale 1ns / 1ps

module cksf_front #(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned CHANNELS  = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [cksf_pkg::WIDTH_W-1:0]   image_width_i,
  input  logic [cksf_pkg::HEIGHT_W-1:0]  image_height_i,
  cksf_stream_if.sink                    pix_i,
  input  logic                           full_i,
  output logic                           push_o,
  output cksf_pkg::item_t                item_o
);

  localparam int unsigned MwW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CmpW = (MwW > cksf_pkg::WIDTH_W) ? MwW : cksf_pkg::WIDTH_W;

  logic [cksf_pkg::COL_W-1:0]  col_q, col_d;
  logic [cksf_pkg::ROW_W-1:0]  row_q, row_d;
  logic [CmpW-1:0]             width_ext, col_last;
  logic [cksf_pkg::ROW_W-1:0]  row_last;
  logic                        last_col, last_row, accept;
  logic [cksf_pkg::PIX_W-1:0]  pix_raw, pixel;

  assign pix_i.ready = !full_i;
  assign accept      = pix_i.valid && !full_i;
  assign push_o      = accept;

  assign pix_raw = {pix_i.payload.chan3_in, pix_i.payload.chan2_in,
                    pix_i.payload.chan1_in, pix_i.payload.chan0_in};

  always_comb begin
    pixel = pix_raw;
    for (int k = 0; k < cksf_pkg::NUM_CH_MAX; k++) begin
      if (k >= CHANNELS) begin
        pixel[k*cksf_pkg::CHAN_W +: cksf_pkg::CHAN_W] = '0;
      end
    end
  end

  // effective last column and last row
  always_comb begin
    width_ext = CmpW'(image_width_i);
    if (width_ext < CmpW'(3)) begin
      col_last = CmpW'(2);
    end else if (width_ext > CmpW'(MAX_WIDTH)) begin
      col_last = CmpW'(MAX_WIDTH - 1);
    end else begin
      col_last = width_ext - CmpW'(1);
    end
    if (image_height_i < cksf_pkg::HEIGHT_W'(3)) begin
      row_last = cksf_pkg::ROW_W'(2);
    end else begin
      row_last = image_height_i - cksf_pkg::ROW_W'(1);
    end
  end

  assign last_col = CmpW'(col_q) >= col_last;
  assign last_row = row_q >= row_last;

  always_comb begin
    item_o.pixel     = pixel;
    item_o.col       = col_q;
    item_o.row       = row_q;
    item_o.has_above = row_q != '0;
    item_o.border    = (row_q == cksf_pkg::ROW_W'(1)) || (col_q == '0) || last_col;
    item_o.last_row  = last_row;
    item_o.last_col  = last_col;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + cksf_pkg::ROW_W'(1);
      end else begin
        col_d = col_q + cksf_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== design/cksf_fifo.sv =====
`timescale 1ns / 1ps

module cksf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cksf_pkg::item_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output cksf_pkg::item_t data_o
);

  cksf_pkg::item_t                entries_q [cksf_pkg::QUEUE_DEPTH];
  logic [cksf_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [cksf_pkg::QPTR_W:0]      cnt_q;

  assign full_o  = cnt_q == (cksf_pkg::QPTR_W + 1)'(cksf_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + cksf_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + cksf_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (cksf_pkg::QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (cksf_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// ===== design/cksf_back.sv =====
`timescale 1ns / 1ps

module cksf_back #(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned CHANNELS  = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cksf_pkg::GAIN_W-1:0]   gain_i,
  input  logic                          q_valid_i,
  input  cksf_pkg::item_t               q_item_i,
  output logic                          q_pop_o,
  cksf_stream_if.source                 res_o
);

  localparam int unsigned AW     = $clog2(MAX_WIDTH);
  localparam int unsigned XW     = ((AW > cksf_pkg::COL_W) ? AW : cksf_pkg::COL_W) + 1;
  localparam int unsigned PIX_W  = cksf_pkg::PIX_W;
  localparam int unsigned MW     = 2 * PIX_W;
  localparam int unsigned CW     = cksf_pkg::CHAN_W;
  localparam int unsigned PROD_W = 2 * CW;
  localparam int unsigned NSUM_W = CW + 2;
  localparam int unsigned DIFF_W = PROD_W + 1;

  // line store word: older row in the upper half, recent row in the lower
  logic [MW-1:0]     mem [MAX_WIDTH];
  logic [MW-1:0]     rd0_q;
  logic [PIX_W-1:0]  rd1_q;

  logic              en;
  logic [XW-1:0]     x0, x1;
  logic              in0, in1;

  logic              s1_vld_q;
  cksf_pkg::item_t   s1_item_q;
  logic              s1_in0_q, s1_in1_q;
  logic [AW-1:0]     s1_addr_q;
  logic [PIX_W-1:0]  above, old_recent, right, left_q;
  logic              wr_en;

  logic              s2_vld_q;
  cksf_pkg::item_t   s2_item_q;
  logic [PROD_W-1:0] prod_q [CHANNELS];
  logic [NSUM_W-1:0] nsum_q [CHANNELS];

  logic              out_vld_q, second_q, sec_done_q;
  cksf_pkg::res_t    out_q, first_res, second_res;
  logic [CW-1:0]     res_ch [cksf_pkg::NUM_CH_MAX];
  logic [DIFF_W-1:0] diff;
  logic              load_first, load_second;

  assign en          = !out_vld_q || (res_o.ready && !second_q);
  assign q_pop_o     = en && q_valid_i;
  assign load_first  = en && s2_vld_q && s2_item_q.has_above;
  assign load_second = !en && res_o.ready && second_q;

  assign x0  = XW'(q_item_i.col);
  assign x1  = x0 + XW'(1);
  assign in0 = x0 < XW'(MAX_WIDTH);
  assign in1 = x1 < XW'(MAX_WIDTH);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_addr_q] <= {old_recent, s1_item_q.pixel};
    end
    if (q_pop_o) begin
      rd0_q     <= mem[x0[AW-1:0]];
      rd1_q     <= mem[x1[AW-1:0]][PIX_W-1:0];
      s1_item_q <= q_item_i;
      s1_in0_q  <= in0;
      s1_in1_q  <= in1;
      s1_addr_q <= x0[AW-1:0];
    end
  end

  assign above      = s1_in0_q ? rd0_q[MW-1:PIX_W] : '0;
  assign old_recent = s1_in0_q ? rd0_q[PIX_W-1:0] : '0;
  assign right      = s1_in1_q ? rd1_q : '0;
  assign wr_en      = en && s1_vld_q && s1_in0_q;

  always_ff @(posedge clk_i) begin
    if (en && s1_vld_q) begin
      s2_item_q <= s1_item_q;
      for (int k = 0; k < CHANNELS; k++) begin
        prod_q[k] <= PROD_W'(gain_i) * PROD_W'(old_recent[k*CW +: CW]);
        nsum_q[k] <= NSUM_W'(left_q[k*CW +: CW]) + NSUM_W'(right[k*CW +: CW])
                   + NSUM_W'(above[k*CW +: CW]) + NSUM_W'(s1_item_q.pixel[k*CW +: CW]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      left_q   <= '0;
    end else if (en) begin
      s1_vld_q <= q_valid_i;
      s2_vld_q <= s1_vld_q;
      if (s1_vld_q) begin
        left_q <= old_recent;
      end
    end
  end

  // saturate gain*centre minus cross sum, zero on border items
  always_comb begin
    diff = '0;
    for (int k = 0; k < cksf_pkg::NUM_CH_MAX; k++) begin
      res_ch[k] = '0;
    end
    for (int k = 0; k < CHANNELS; k++) begin
      diff = DIFF_W'(prod_q[k]) - DIFF_W'(nsum_q[k]);
      if (s2_item_q.border || diff[DIFF_W-1]) begin
        res_ch[k] = '0;
      end else if (|diff[DIFF_W-2:CW]) begin
        res_ch[k] = '1;
      end else begin
        res_ch[k] = diff[CW-1:0];
      end
    end
  end

  always_comb begin
    first_res.chan0_out    = res_ch[0];
    first_res.chan1_out    = res_ch[1];
    first_res.chan2_out    = res_ch[2];
    first_res.chan3_out    = res_ch[3];
    first_res.out_col      = s2_item_q.col;
    first_res.out_row      = s2_item_q.row - cksf_pkg::ROW_W'(1);
    first_res.last_of_item = !s2_item_q.last_row;
    first_res.frame_done   = 1'b0;

    second_res.chan0_out    = '0;
    second_res.chan1_out    = '0;
    second_res.chan2_out    = '0;
    second_res.chan3_out    = '0;
    second_res.out_col      = out_q.out_col;
    second_res.out_row      = out_q.out_row + cksf_pkg::ROW_W'(1);
    second_res.last_of_item = 1'b1;
    second_res.frame_done   = sec_done_q;
  end

  always_ff @(posedge clk_i) begin
    if (load_first) begin
      out_q      <= first_res;
      sec_done_q <= s2_item_q.last_col;
    end else if (load_second) begin
      out_q <= second_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      second_q  <= 1'b0;
    end else if (en) begin
      out_vld_q <= load_first;
      second_q  <= load_first && s2_item_q.last_row;
    end else if (load_second) begin
      second_q <= 1'b0;
    end
  end

  assign res_o.valid   = out_vld_q;
  assign res_o.payload = out_q;

endmodule

// ===== design/cksf_checker.sv =====
`timescale 1ns / 1ps
`include "cross_kernel_sharpen_filter_defines.svh"

module cksf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           res_valid_i,
  input logic           res_ready_i,
  input cksf_pkg::res_t res_i
);

  logic res_zero;
  assign res_zero = (res_i.chan0_out == '0) && (res_i.chan1_out == '0)
                 && (res_i.chan2_out == '0) && (res_i.chan3_out == '0);

  `CKSF_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(res_i), "result item changed while stalled")
  `CKSF_ASSERT_NOW(a_done_last, clk_i, rst_ni, res_valid_i && res_i.frame_done, res_i.last_of_item, "frame end not on last item")
  `CKSF_ASSERT_NOW(a_done_zero, clk_i, rst_ni, res_valid_i && res_i.frame_done, res_zero, "frame end pixel not a zero border")
  `CKSF_ASSERT_NEXT(a_pair, clk_i, rst_ni, res_valid_i && res_ready_i && !res_i.last_of_item, res_valid_i && res_i.last_of_item && res_zero && (res_i.out_col == $past(res_i.out_col)) && (res_i.out_row == 16'($past(res_i.out_row) + 16'd1)), "last-row border item missing")

endmodule

bind cross_kernel_sharpen_filter cksf_checker u_cksf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_i       (res_o.payload)
);

// ===== dv/cross_kernel_sharpen_filter_checker.sv =====
`timescale 1ns / 1ps

module cross_kernel_sharpen_filter_checker
  import cksf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned CHANNELS  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  pix_valid_i,
  input  logic                  pix_ready_i,
  input  pix_t                  pix_data_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  res_t                  res_data_i,
  output int unsigned           pending_o,
  output int unsigned           fail_count_o
);

  logic [PIX_W-1:0]    older_row [MAX_WIDTH];
  logic [PIX_W-1:0]    recent_row [MAX_WIDTH];
  logic [PIX_W-1:0]    left_hold;
  logic [COL_W-1:0]    col_cnt;
  logic [ROW_W-1:0]    row_cnt;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [GAIN_W-1:0]   gain_reg;

  res_t        sharpened_q[$];
  res_t        want;
  int unsigned mismatches;

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // One pixel in: result for the pixel above, plus the zero border result on the last row.
  task automatic sharpen_pixel(input pix_t pix);
    int unsigned      w, h, x, y;
    int               v;
    logic [PIX_W-1:0] cur, above, right, old_recent, left;
    logic [CHAN_W-1:0] res_ch [NUM_CH_MAX];
    bit               last_col, last_row, border;
    res_t             r;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_reg;
    if (h < 3) h = 3;
    x = col_cnt;
    y = row_cnt;
    last_col = (x >= w - 1);
    last_row = (y >= h - 1);
    cur = {pix.chan3_in, pix.chan2_in, pix.chan1_in, pix.chan0_in};
    for (int k = 0; k < NUM_CH_MAX; k++) begin
      if (k >= CHANNELS) cur[8*k +: 8] = '0;
    end
    above = '0;
    old_recent = '0;
    right = '0;
    if (x < MAX_WIDTH) begin
      above = older_row[x];
      old_recent = recent_row[x];
    end
    if (x + 1 < MAX_WIDTH) right = recent_row[x + 1];
    left = left_hold;
    if (y >= 1) begin
      border = (y == 1) || (x == 0) || last_col;
      for (int k = 0; k < NUM_CH_MAX; k++) res_ch[k] = '0;
      if (!border) begin
        for (int k = 0; k < NUM_CH_MAX; k++) begin
          if (k < CHANNELS) begin
            v = int'(gain_reg) * int'(old_recent[8*k +: 8]) - int'(left[8*k +: 8])
              - int'(right[8*k +: 8]) - int'(above[8*k +: 8]) - int'(cur[8*k +: 8]);
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            res_ch[k] = CHAN_W'(v);
          end
        end
      end
      r = '0;
      r.chan0_out = res_ch[0];
      r.chan1_out = res_ch[1];
      r.chan2_out = res_ch[2];
      r.chan3_out = res_ch[3];
      r.out_col = COL_W'(x);
      r.out_row = ROW_W'(y - 1);
      r.last_of_item = !last_row;
      r.frame_done = 1'b0;
      sharpened_q.push_back(r);
      if (last_row) begin
        r = '0;
        r.out_col = COL_W'(x);
        r.out_row = ROW_W'(y);
        r.last_of_item = 1'b1;
        r.frame_done = last_col;
        sharpened_q.push_back(r);
      end
    end
    if (x < MAX_WIDTH) begin
      older_row[x] = old_recent;
      recent_row[x] = cur;
    end
    left_hold = old_recent;
    if (last_col) begin
      col_cnt = '0;
      row_cnt = last_row ? '0 : ROW_W'(y + 1);
    end else begin
      col_cnt = COL_W'(x + 1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        older_row[i] = '0;
        recent_row[i] = '0;
      end
      left_hold = '0;
      col_cnt = '0;
      row_cnt = '0;
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      gain_reg = GAIN_RST;
      sharpened_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_WIDTH:  width_reg = cfg_data_i[WIDTH_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_data_i[HEIGHT_W-1:0];
          CFG_CENTER_GAIN:  gain_reg = cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (sharpened_q.size() == 0) begin
          $error("unexpected result: col %0d row %0d", res_data_i.out_col,
                 res_data_i.out_row);
          mismatches++;
        end else begin
          want = sharpened_q.pop_front();
          compare_field("chan0_out", 32'(want.chan0_out), 32'(res_data_i.chan0_out));
          compare_field("chan1_out", 32'(want.chan1_out), 32'(res_data_i.chan1_out));
          compare_field("chan2_out", 32'(want.chan2_out), 32'(res_data_i.chan2_out));
          compare_field("chan3_out", 32'(want.chan3_out), 32'(res_data_i.chan3_out));
          compare_field("out_col", 32'(want.out_col), 32'(res_data_i.out_col));
          compare_field("out_row", 32'(want.out_row), 32'(res_data_i.out_row));
          compare_field("last_of_item", 32'(want.last_of_item),
                        32'(res_data_i.last_of_item));
          compare_field("frame_done", 32'(want.frame_done), 32'(res_data_i.frame_done));
        end
      end
      if (pix_valid_i && pix_ready_i) sharpen_pixel(pix_data_i);
    end
    pending_o <= sharpened_q.size();
    fail_count_o <= mismatches;
  end

endmodule

// ===== dv/cross_kernel_sharpen_filter_test.sv =====
`timescale 1ns / 1ps

module cross_kernel_sharpen_filter_test;
  import cksf_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned DRAIN       = 16;

  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_EXTREME,
    FILL_SMOOTH
  } fill_e;

  typedef enum int unsigned {
    CUT_NONE,
    CUT_GAIN,
    CUT_HEIGHT,
    CUT_WIDTH
  } cut_e;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    idling_on;
  int unsigned           items_sent;
  int unsigned           stall_cnt;
  int unsigned           quiet_cycles;
  int unsigned           pending;
  int unsigned           fail_count;

  cksf_stream_if #(.T(pix_t)) pix_if ();
  cksf_stream_if #(.T(res_t)) res_if ();

  cross_kernel_sharpen_filter u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  cross_kernel_sharpen_filter_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pix_valid_i  (pix_if.valid),
    .pix_ready_i  (pix_if.ready),
    .pix_data_i   (pix_if.payload),
    .res_valid_i  (res_if.valid),
    .res_ready_i  (res_if.ready),
    .res_data_i   (res_if.payload),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side back-pressure
  initial begin
    res_if.ready = 1'b1;
    stall_cnt = 0;
    forever begin
      @(posedge clk);
      if (stall_cnt != 0) begin
        stall_cnt--;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        stall_cnt = $urandom_range(1, 19);
      end
      res_if.ready <= (stall_cnt == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    quiet_cycles = 0;
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [CHAN_W-1:0] pick_chan(input fill_e mode);
    case (mode)
      FILL_RANDOM: return CHAN_W'($urandom_range(0, 255));
      FILL_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 8'h00;
          1: return 8'hFF;
          2: return CHAN_W'(1 << $urandom_range(0, 7));
          default: return ~CHAN_W'(1 << $urandom_range(0, 7));
        endcase
      end
      default: return CHAN_W'($urandom_range(58, 72));
    endcase
  endfunction

  function automatic pix_t make_pixel(input fill_e mode);
    pix_t p;
    p.chan0_in = pick_chan(mode);
    p.chan1_in = pick_chan(mode);
    p.chan2_in = pick_chan(mode);
    p.chan3_in = pick_chan(mode);
    return p;
  endfunction

  task automatic send_pixel(input pix_t p);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.payload <= p;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // stop the stream and let every result out before touching a register
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_frame(input int unsigned w_reg, input int unsigned h_reg,
                           input int unsigned gain, input fill_e mode,
                           input int unsigned pause_at, input cut_e cut);
    int unsigned eff_w, eff_h, x, y, n;
    bit          done;
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w_reg));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h_reg));
    write_reg(CFG_CENTER_GAIN, CFG_DATA_W'(gain));
    eff_w = (w_reg < 3) ? 3 : (w_reg > 2048) ? 2048 : w_reg;
    eff_h = (h_reg < 3) ? 3 : h_reg;
    x = 0;
    y = 0;
    n = 0;
    done = 1'b0;
    while (!done) begin
      if (n == pause_at && cut != CUT_NONE) begin
        wait_idle();
        case (cut)
          CUT_GAIN: write_reg(CFG_CENTER_GAIN, CFG_DATA_W'($urandom_range(0, 255)));
          CUT_HEIGHT: begin
            write_reg(CFG_IMAGE_HEIGHT, 16'd3);
            eff_h = 3;
          end
          default: begin
            write_reg(CFG_IMAGE_WIDTH, 16'd3);
            eff_w = 3;
          end
        endcase
      end
      send_pixel(make_pixel(mode));
      n++;
      if (x >= eff_w - 1) begin
        x = 0;
        if (y >= eff_h - 1) done = 1'b1;
        else y++;
      end else begin
        x++;
      end
    end
  endtask

  initial begin
    int unsigned r, w, h, g, total, pause_at, stop_at;
    cut_e        cut;
    pix_t        p;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    pix_if.valid = 1'b0;
    pix_if.payload = '0;
    idling_on = 1'b1;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // saturating high: bright centre, dark cross, full gain
    write_reg(CFG_IMAGE_WIDTH, 16'd3);
    write_reg(CFG_IMAGE_HEIGHT, 16'd3);
    write_reg(CFG_CENTER_GAIN, 16'd255);
    for (int i = 0; i < 9; i++) begin
      p = (i == 4) ? '1 : '0;
      send_pixel(p);
    end
    // clamp at zero, and sizes below the minimum
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 16'd0);
    write_reg(CFG_IMAGE_HEIGHT, 16'd1);
    write_reg(CFG_CENTER_GAIN, 16'd0);
    for (int i = 0; i < 9; i++) send_pixel('1);

    while (items_sent < 360) begin
      idling_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 19);
      w = (r < 2) ? $urandom_range(0, 2) : (r == 2) ? $urandom_range(13, 40)
                                                     : $urandom_range(3, 12);
      h = ($urandom_range(0, 9) < 2) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      r = $urandom_range(0, 19);
      g = (r < 3) ? 0 : (r < 6) ? 255 : (r < 14) ? $urandom_range(3, 6)
                                                  : $urandom_range(0, 255);
      total = ((w < 3) ? 3 : w) * ((h < 3) ? 3 : h);
      pause_at = $urandom_range(1, total - 1);
      cut = ($urandom_range(0, 4) == 0) ? cut_e'($urandom_range(1, 3)) : CUT_NONE;
      run_frame(w, h, g, fill_e'($urandom_range(0, 2)), pause_at, cut);
    end

    // tallest height, cut short by lowering the height mid-frame
    idling_on = 1'b1;
    run_frame(4, 16'hFFFF, 255, FILL_RANDOM, 17, CUT_HEIGHT);
    // widest register value, then narrowed part way along the first row
    run_frame(12'hFFF, 2, $urandom_range(0, 255), FILL_RANDOM, 30, CUT_WIDTH);

    idling_on = 1'b0;
    stop_at = items_sent + 60;
    while (items_sent < stop_at) begin
      run_frame($urandom_range(3, 10), $urandom_range(3, 5), $urandom_range(0, 255),
                fill_e'($urandom_range(0, 2)), 0, CUT_NONE);
    end

    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
